### src/nrcs_pkg.sv
// shared constants and types for the nearest reference color search
package nrcs_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int COLOR_W = 8;
    localparam int INDEX_W = 4;
    localparam int DIST_W = 18;
    localparam int COUNT_W = 2;
    localparam int USED_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 18;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST_SQ = 2'd2;

    localparam logic [DIST_W-1:0] DIST_RESET = 18'd195075;
    localparam logic [COUNT_W-1:0] TOP_N = 2'd3;

    typedef struct packed {
        logic load;
        logic add;
    } t_dist_ctl;

endpackage

### src/nrcs_dist.sv
// squared color distance accumulator, one component per cycle
module nrcs_dist
    import nrcs_pkg::*;
(
    input  logic               i_clk,
    input  t_dist_ctl          i_ctl,
    input  logic [COLOR_W-1:0] i_a,
    input  logic [COLOR_W-1:0] i_b,
    output logic [DIST_W-1:0]  o_dist
);

    logic [COLOR_W-1:0]   diff;
    logic [2*COLOR_W-1:0] sq;
    logic [DIST_W-1:0]    r_acc;

    assign diff = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
    assign sq = diff * diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= DIST_W'(sq);
        end else if (i_ctl.add) begin
            r_acc <= r_acc + DIST_W'(sq);
        end
    end

    assign o_dist = r_acc;

endmodule

### src/nearest_reference_color_search.sv
// top level of the nearest reference color search
//
// Holds a table of ENTRIES reference RGB colors (24 bits each, memory with
// one write port and one registered read port). A write item stores one color
// and leaves no result. A query item walks the first entries_used slots
// (saturated to ENTRIES) and keeps the three nearest by squared distance,
// ties to the lower slot. One shared squarer handles one color component per
// cycle, so each searched slot passes through a table read, red, green, blue
// and ranking step; the block takes no new item from acceptance of a query
// until its result has been loaded into the output register.
// The output register lets the next item in while a result still waits.
// Slots searched must have been written since reset.
module nearest_reference_color_search
    import nrcs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_cmd,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [COLOR_W-1:0]    i_red,
    input  logic [COLOR_W-1:0]    i_green,
    input  logic [COLOR_W-1:0]    i_blue,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_found,
    output logic [INDEX_W-1:0]    o_best_index,
    output logic [DIST_W-1:0]     o_best_dist_sq,
    output logic [INDEX_W-1:0]    o_second_index,
    output logic [INDEX_W-1:0]    o_third_index,
    output logic [COUNT_W-1:0]    o_match_count
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WORD_W = 3 * COLOR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_RED   = 3'd2;
    localparam logic [2:0] S_GREEN = 3'd3;
    localparam logic [2:0] S_BLUE  = 3'd4;
    localparam logic [2:0] S_INS   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    // configuration registers
    logic [USED_W-1:0] r_entries_used;
    logic              r_thr_en;
    logic [DIST_W-1:0] r_max_dist;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_n, n_n;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [DIST_W-1:0]  r_sel_dist [3];
    logic [DIST_W-1:0]  n_sel_dist [3];
    logic [AW-1:0]      r_sel_idx [3];
    logic [AW-1:0]      n_sel_idx [3];
    logic [COLOR_W-1:0] r_qr, r_qg, r_qb;

    logic [WORD_W-1:0]  mem [ENTRIES];
    logic [WORD_W-1:0]  r_rdata;

    logic               in_acc;
    logic               wr_en;
    logic               out_free;
    logic               fin_load;
    logic               found;
    logic [CW-1:0]      used_sat;

    t_dist_ctl          dist_ctl;
    logic [COLOR_W-1:0] comp_a, comp_b;
    logic [DIST_W-1:0]  cur_dist;

    logic [2:0]         lt;
    logic [COUNT_W-1:0] n_lt;
    logic [COUNT_W-1:0] pos;

    logic               r_o_valid;
    logic               r_o_found;
    logic [INDEX_W-1:0] r_o_best_index;
    logic [DIST_W-1:0]  r_o_best_dist;
    logic [INDEX_W-1:0] r_o_second_index;
    logic [INDEX_W-1:0] r_o_third_index;
    logic [COUNT_W-1:0] r_o_count;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign wr_en    = in_acc && (i_cmd == CMD_WRITE) && (32'(i_entry_index) < 32'(ENTRIES));
    assign out_free = !r_o_valid || !i_stall;
    assign fin_load = (r_state == S_FIN) && out_free;
    assign used_sat = (32'(r_entries_used) > 32'(ENTRIES)) ? CW'(ENTRIES)
                                                          : CW'(r_entries_used);
    assign found    = (r_cnt != '0) && (!r_thr_en || (r_sel_dist[0] <= r_max_dist));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_used <= '0;
            r_thr_en       <= 1'b0;
            r_max_dist     <= DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ENTRIES_USED: r_entries_used <= i_cfg_data[USED_W-1:0];
                CFG_THRESHOLD_EN: r_thr_en <= i_cfg_data[0];
                CFG_MAX_DIST_SQ:  r_max_dist <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // reference table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_entry_index)] <= {i_red, i_green, i_blue};
        end
        r_rdata <= mem[r_idx[AW-1:0]];
    end

    // component select for the shared squarer
    always_comb begin
        dist_ctl = '0;
        comp_a   = r_rdata[WORD_W-1 -: COLOR_W];
        comp_b   = r_qr;
        case (r_state)
            S_RED: begin
                dist_ctl.load = 1'b1;
            end
            S_GREEN: begin
                dist_ctl.add = 1'b1;
                comp_a       = r_rdata[2*COLOR_W-1 -: COLOR_W];
                comp_b       = r_qg;
            end
            S_BLUE: begin
                dist_ctl.add = 1'b1;
                comp_a       = r_rdata[COLOR_W-1:0];
                comp_b       = r_qb;
            end
            default: ;
        endcase
    end

    nrcs_dist u_dist (
        .i_clk  (i_clk),
        .i_ctl  (dist_ctl),
        .i_a    (comp_a),
        .i_b    (comp_b),
        .o_dist (cur_dist)
    );

    // ranking: kept list is sorted, so the entries the new distance beats form a tail
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lt[k] = (COUNT_W'(k) < r_cnt) && (cur_dist < r_sel_dist[k]);
        end
        n_lt = COUNT_W'(lt[0]) + COUNT_W'(lt[1]) + COUNT_W'(lt[2]);
        pos  = r_cnt - n_lt;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_sel_dist = r_sel_dist;
        n_sel_idx  = r_sel_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_QUERY)) begin
                    n_idx      = '0;
                    n_n        = used_sat;
                    n_cnt      = '0;
                    n_sel_dist = '{default: '0};
                    n_sel_idx  = '{default: '0};
                    n_state    = (used_sat == '0) ? S_FIN : S_READ;
                end
            end
            S_READ:  n_state = S_RED;
            S_RED:   n_state = S_GREEN;
            S_GREEN: n_state = S_BLUE;
            S_BLUE:  n_state = S_INS;
            S_INS: begin
                if (pos == 2'd0) begin
                    n_sel_dist[2] = r_sel_dist[1];
                    n_sel_idx[2]  = r_sel_idx[1];
                    n_sel_dist[1] = r_sel_dist[0];
                    n_sel_idx[1]  = r_sel_idx[0];
                    n_sel_dist[0] = cur_dist;
                    n_sel_idx[0]  = r_idx[AW-1:0];
                end else if (pos == 2'd1) begin
                    n_sel_dist[2] = r_sel_dist[1];
                    n_sel_idx[2]  = r_sel_idx[1];
                    n_sel_dist[1] = cur_dist;
                    n_sel_idx[1]  = r_idx[AW-1:0];
                end else if (pos == 2'd2) begin
                    n_sel_dist[2] = cur_dist;
                    n_sel_idx[2]  = r_idx[AW-1:0];
                end
                if (r_cnt != TOP_N) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (CW'(r_idx + 1'b1) == r_n) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = CW'(r_idx + 1'b1);
                    n_state = S_READ;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel_dist <= n_sel_dist;
        r_sel_idx  <= n_sel_idx;
        if (in_acc) begin
            r_qr <= i_red;
            r_qg <= i_green;
            r_qb <= i_blue;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fin_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_o_found        <= found;
            r_o_best_index   <= INDEX_W'(r_sel_idx[0]);
            r_o_best_dist    <= r_sel_dist[0];
            r_o_second_index <= INDEX_W'(r_sel_idx[1]);
            r_o_third_index  <= INDEX_W'(r_sel_idx[2]);
            r_o_count        <= r_cnt;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_best_index   = r_o_best_index;
    assign o_best_dist_sq = r_o_best_dist;
    assign o_second_index = r_o_second_index;
    assign o_third_index  = r_o_third_index;
    assign o_match_count  = r_o_count;

    // kept distances stay sorted nearest first
    a_sorted_01: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= 2'd2) |-> (r_sel_dist[0] <= r_sel_dist[1]))
        else $error("ranking out of order in first two places");

    a_sorted_12: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == TOP_N) |-> (r_sel_dist[1] <= r_sel_dist[2]))
        else $error("ranking out of order in last two places");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_match_count != '0))
        else $error("match reported with an empty ranking");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_WRITE) && !r_o_valid) |=> !r_o_valid)
        else $error("write item produced a result");

endmodule

### verif/nearest_reference_color_search_tb.sv
// self-checking testbench for the nearest reference color search block
`timescale 1ns / 100ps

module nearest_reference_color_search_tb;
    import nrcs_pkg::*;

    localparam int TOP_SLOTS = TOP_N;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SHOW_LIMIT = 60;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] best_index;
        logic [DIST_W-1:0]  best_dist_sq;
        logic [INDEX_W-1:0] second_index;
        logic [INDEX_W-1:0] third_index;
        logic [COUNT_W-1:0] match_count;
    } t_match;

    class nearest_match_board;
        logic [3*COLOR_W-1:0] palette [ENTRIES_DEF];
        int unsigned used_slots;
        bit limit_on;
        int unsigned dist_limit;
        t_match pending_matches [$];
        int unsigned mismatches;
        int unsigned writes_seen;
        int unsigned queries_seen;
        int unsigned results_seen;

        function new();
            foreach (palette[i]) palette[i] = '0;
            used_slots = 0;
            limit_on = 1'b0;
            dist_limit = DIST_RESET;
            mismatches = 0;
            writes_seen = 0;
            queries_seen = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_ENTRIES_USED: used_slots = data[USED_W-1:0];
                CFG_THRESHOLD_EN: limit_on = data[0];
                CFG_MAX_DIST_SQ:  dist_limit = data;
                default: ;
            endcase
        endfunction

        // keeps the three nearest slots, strict compare so ties stay with the lower slot
        function t_match rank_nearest(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned n, cnt, pos, k, s, d;
            int unsigned near_slot [TOP_SLOTS];
            int unsigned near_gap [TOP_SLOTS];
            int dr, dg, db;
            t_match m;
            n = (used_slots > ENTRIES_DEF) ? ENTRIES_DEF : used_slots;
            cnt = 0;
            for (k = 0; k < TOP_SLOTS; k++) begin
                near_slot[k] = 0;
                near_gap[k] = 0;
            end
            for (s = 0; s < n; s++) begin
                dr = int'(palette[s][23:16]) - int'(r);
                dg = int'(palette[s][15:8]) - int'(g);
                db = int'(palette[s][7:0]) - int'(b);
                d = dr * dr + dg * dg + db * db;
                pos = cnt;
                while (pos > 0 && d < near_gap[pos-1]) pos--;
                if (pos < TOP_SLOTS) begin
                    k = (cnt < TOP_SLOTS) ? cnt : TOP_SLOTS - 1;
                    while (k > pos) begin
                        near_gap[k] = near_gap[k-1];
                        near_slot[k] = near_slot[k-1];
                        k--;
                    end
                    near_gap[pos] = d;
                    near_slot[pos] = s;
                    if (cnt < TOP_SLOTS) cnt++;
                end
            end
            m.found = (cnt > 0) && (!limit_on || near_gap[0] <= dist_limit);
            m.best_index = INDEX_W'(near_slot[0]);
            m.best_dist_sq = DIST_W'(near_gap[0]);
            m.second_index = INDEX_W'(near_slot[1]);
            m.third_index = INDEX_W'(near_slot[2]);
            m.match_count = COUNT_W'(cnt);
            return m;
        endfunction

        function void note_item(logic cmd, logic [INDEX_W-1:0] idx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
            if (cmd == CMD_WRITE) begin
                palette[idx] = {r, g, b};
                writes_seen++;
            end else begin
                pending_matches.push_back(rank_nearest(r, g, b));
                queries_seen++;
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                else if (mismatches == SHOW_LIMIT + 1)
                    $display("%0t: further mismatches counted but not shown", $time);
            end
        endfunction

        function void check_result(t_match got);
            t_match want;
            results_seen++;
            if (pending_matches.size() == 0) begin
                mismatches++;
                $display("%0t: result with no query pending, expected none, got best %0d dist %0d",
                         $time, got.best_index, got.best_dist_sq);
                return;
            end
            want = pending_matches.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("best_index", want.best_index, got.best_index);
            compare_field("best_dist_sq", want.best_dist_sq, got.best_dist_sq);
            compare_field("second_index", want.second_index, got.second_index);
            compare_field("third_index", want.third_index, got.third_index);
            compare_field("match_count", want.match_count, got.match_count);
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_cmd;
    logic [INDEX_W-1:0]    i_entry_index;
    logic [COLOR_W-1:0]    i_red;
    logic [COLOR_W-1:0]    i_green;
    logic [COLOR_W-1:0]    i_blue;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_found;
    logic [INDEX_W-1:0]    o_best_index;
    logic [DIST_W-1:0]     o_best_dist_sq;
    logic [INDEX_W-1:0]    o_second_index;
    logic [INDEX_W-1:0]    o_third_index;
    logic [COUNT_W-1:0]    o_match_count;

    nearest_match_board board;
    t_match dut_match;
    logic hold_request;
    bit hold_done = 1'b0;
    int stall_left = 0;
    int rx_cycles = 0;
    int idle_cycles = 0;
    int settings_done = 0;

    assign dut_match = {o_found, o_best_index, o_best_dist_sq,
                        o_second_index, o_third_index, o_match_count};

    nearest_reference_color_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_best_index   (o_best_index),
        .o_best_dist_sq (o_best_dist_sq),
        .o_second_index (o_second_index),
        .o_third_index  (o_third_index),
        .o_match_count  (o_match_count)
    );

    always #5 i_clk = ~i_clk;

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(dut_match);
        rx_cycles++;
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
        end else if (stall_left == 0 && (rx_cycles / 700) % 3 != 0
                     && $urandom_range(5, 0) == 0) begin
            stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(3, 1);
        end
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d queries outstanding",
                     $time, idle_cycles, board.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6, 0)) - 3;
        if (v < 0) v = 0;
        else if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] coarse_tone();
        case ($urandom_range(3, 0))
            0: return 8'h00;
            1: return 8'h40;
            2: return 8'h80;
            default: return 8'hff;
        endcase
    endfunction

    task automatic offer_item(logic cmd, logic [INDEX_W-1:0] idx,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b, bit calm);
        int unsigned gap;
        int unsigned roll;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_entry_index <= idx;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_item(cmd, idx, r, g, b);
        roll = $urandom_range(99, 0);
        if (calm || roll < 60) gap = 0;
        else if (roll < 92) gap = $urandom_range(3, 1);
        else gap = $urandom_range(40, 10);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (board.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic put_register(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_register(addr, data);
    endtask

    // registers change only with the block idle
    task automatic settle_and_set(int unsigned used, bit limit_en, int unsigned limit);
        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        put_register(CFG_ENTRIES_USED, CFG_DATA_W'(used));
        put_register(CFG_THRESHOLD_EN, CFG_DATA_W'(limit_en));
        put_register(CFG_MAX_DIST_SQ, CFG_DATA_W'(limit));
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    initial begin : stimulus
        logic [3*COLOR_W-1:0] seed_colors [8];
        int unsigned phase_used [RANDOM_PHASES];
        int unsigned p, k, slot, pick, limit;
        logic cmd;
        logic [INDEX_W-1:0] idx;
        logic [7:0] r, g, b;
        bit calm;

        board = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_cmd <= CMD_WRITE;
        i_entry_index <= '0;
        i_red <= '0;
        i_green <= '0;
        i_blue <= '0;
        hold_request <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, before any slot is written
        settle_and_set(0, 1'b0, DIST_RESET);
        offer_item(CMD_QUERY, 4'hf, 8'hff, 8'h00, 8'h80, 1'b0);

        // black, white, primaries, a duplicate black for ties, two grays
        seed_colors = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
                        24'h0000ff, 24'h000000, 24'h808080, 24'h7f7f7f};
        for (k = 0; k < ENTRIES_DEF; k++) begin
            {r, g, b} = (k < 8) ? seed_colors[k] : 24'($urandom);
            offer_item(CMD_WRITE, INDEX_W'(k), r, g, b, 1'b0);
        end

        // farthest possible color, right at the limit
        settle_and_set(1, 1'b1, DIST_RESET);
        offer_item(CMD_QUERY, 4'h0, 8'hff, 8'hff, 8'hff, 1'b0);
        // zero limit: exact hit passes, one step off fails
        settle_and_set(1, 1'b1, 0);
        offer_item(CMD_QUERY, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0);
        offer_item(CMD_QUERY, 4'h0, 8'h01, 8'h00, 8'h00, 1'b0);
        // fewer than three slots searched
        settle_and_set(2, 1'b0, DIST_RESET);
        offer_item(CMD_QUERY, 4'h0, 8'h80, 8'h80, 8'h80, 1'b0);
        // full table, tie between the two black slots
        settle_and_set(ENTRIES_DEF, 1'b1, DIST_RESET);
        offer_item(CMD_QUERY, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0);
        offer_item(CMD_QUERY, 4'h0, 8'h7f, 8'h7f, 8'h7f, 1'b0);
        offer_item(CMD_QUERY, 4'h0, 8'hff, 8'hff, 8'hff, 1'b0);
        // count above the table size saturates, widest limit
        settle_and_set(31, 1'b1, (1 << DIST_W) - 1);
        offer_item(CMD_QUERY, 4'h0, 8'hff, 8'h00, 8'h00, 1'b0);

        phase_used = '{3, 16, 1, 2, 8, 16, 0, 31, 5, 12};
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(3, 0))
                0: limit = 0;
                1: limit = $urandom_range(2000, 0);
                2: limit = $urandom_range((1 << DIST_W) - 1, 0);
                default: limit = DIST_RESET;
            endcase
            settle_and_set(phase_used[p], bit'(p % 2), limit);
            // short searches here, so a long receiver hold backs up into the input
            if (p == 0) hold_request <= 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                calm = ((k / 40) % 4) == 3;
                if (k == ITEMS_PER_PHASE / 2) begin
                    i_valid <= 1'b0;
                    drain_results();
                end
                idx = INDEX_W'($urandom_range(15, 0));
                if ($urandom_range(9, 0) < 3) begin
                    cmd = CMD_WRITE;
                    if ($urandom_range(1, 0) != 0) begin
                        {r, g, b} = 24'($urandom);
                    end else begin
                        r = coarse_tone();
                        g = coarse_tone();
                        b = coarse_tone();
                    end
                end else begin
                    cmd = CMD_QUERY;
                    pick = $urandom_range(99, 0);
                    slot = $urandom_range(ENTRIES_DEF - 1, 0);
                    if (pick < 30) begin
                        {r, g, b} = board.palette[slot];
                    end else if (pick < 50) begin
                        r = nudge(board.palette[slot][23:16]);
                        g = nudge(board.palette[slot][15:8]);
                        b = nudge(board.palette[slot][7:0]);
                    end else if (pick < 65) begin
                        r = coarse_tone();
                        g = coarse_tone();
                        b = coarse_tone();
                    end else begin
                        {r, g, b} = 24'($urandom);
                    end
                end
                offer_item(cmd, idx, r, g, b, calm);
            end
        end

        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d table writes and %0d queries, %0d results checked",
                 board.writes_seen, board.queries_seen, board.results_seen);
        $display("over %0d register settings, entries_used 0 to 31, limits 0 to full scale",
                 settings_done);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
src/nrcs_pkg.sv
src/nrcs_dist.sv
src/nearest_reference_color_search.sv
verif/nearest_reference_color_search_tb.sv
